/* rtl/fwes_pkg.sv */
// Package for the flash write/erase splitter.
// Holds the job descriptor passed from front to back, and the operation,
// status and register codes. No dependencies.
package fwes_pkg;

  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned COUNT_W  = 18;
  localparam int unsigned BYTES_W  = 9;
  localparam int unsigned REGEND_W = 25;

  // At most this many operations are issued for one request.
  localparam int unsigned RESULT_LIMIT = 33;
  localparam int unsigned RESULT_CNT_W = $clog2(RESULT_LIMIT);

  // Entries in the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation codes.
  localparam logic [1:0] OP_PROGRAM   = 2'd0;
  localparam logic [1:0] OP_SECTOR    = 2'd1;
  localparam logic [1:0] OP_SUBSECTOR = 2'd2;
  localparam logic [1:0] OP_NONE      = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REGION = 2'd1;
  localparam logic [1:0] ST_ALIGN  = 2'd2;
  localparam logic [1:0] ST_LONG   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_END   = 1'b1;

  // What the back end has to do with a request.
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_WRITE,
    JOB_ERASE
  } job_kind_e;

  // One classified request.
  typedef struct packed {
    job_kind_e          kind;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } job_t;

endpackage

/* rtl/fwes_front.sv */
// Front end of the splitter: holds the region registers and classifies each
// incoming request into a job for the queue. Depends on fwes_pkg.
module fwes_front import fwes_pkg::*; #(
  parameter int unsigned SUBSECTOR_BYTES = 4096,
  parameter int unsigned MAX_WRITE_BYTES = 8192,
  parameter int unsigned MAX_ERASE_BYTES = 131072
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_valid_i,
  input  logic                cfg_index_i,
  input  logic [REGEND_W-1:0] cfg_data_i,
  // Request channel
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic                req_cmd_i,
  input  logic [ADDR_W-1:0]   req_addr_i,
  input  logic [COUNT_W-1:0]  req_count_i,
  // Queue push side
  input  logic                full_i,
  output logic                push_o,
  output job_t                job_o
);

  localparam logic [ADDR_W-1:0]  SubMaskA = ADDR_W'(SUBSECTOR_BYTES - 1);
  localparam logic [COUNT_W-1:0] SubMaskC = COUNT_W'(SUBSECTOR_BYTES - 1);
  localparam logic [COUNT_W-1:0] MaxWrite = COUNT_W'(MAX_WRITE_BYTES);
  localparam logic [COUNT_W-1:0] MaxErase = COUNT_W'(MAX_ERASE_BYTES);

  logic [ADDR_W-1:0]   region_start_q;
  logic [REGEND_W-1:0] region_end_q;
  logic [REGEND_W-1:0] end_addr;

  // Region registers, written one transfer at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      region_end_q   <= REGEND_W'(1) << ADDR_W;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_REGION_START) begin
        region_start_q <= cfg_data_i[ADDR_W-1:0];
      end else begin
        region_end_q <= cfg_data_i;
      end
    end
  end

  assign end_addr = REGEND_W'(req_addr_i) + REGEND_W'(req_count_i);

  // Checks in the order of precedence: length, then region or alignment,
  // then the empty request.
  always_comb begin
    job_o.addr   = req_addr_i;
    job_o.count  = req_count_i;
    job_o.kind   = JOB_NONE;
    job_o.status = ST_OK;
    if (!req_cmd_i) begin
      if (req_count_i > MaxWrite) begin
        job_o.status = ST_LONG;
      end else if (req_addr_i < region_start_q || end_addr > region_end_q) begin
        job_o.status = ST_REGION;
      end else if (req_count_i != '0) begin
        job_o.kind = JOB_WRITE;
      end
    end else begin
      if (req_count_i > MaxErase) begin
        job_o.status = ST_LONG;
      end else if ((req_addr_i & SubMaskA) != '0 || (req_count_i & SubMaskC) != '0) begin
        job_o.status = ST_ALIGN;
      end else if (req_count_i != '0) begin
        job_o.kind = JOB_ERASE;
      end
    end
  end

  assign req_ready_o = !full_i;
  assign push_o      = req_valid_i && !full_i;

endmodule

/* rtl/fwes_queue.sv */
// Short job queue between the front and back ends of the splitter.
// Depends on fwes_pkg for the job type.
module fwes_queue import fwes_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* rtl/fwes_back.sv */
// Back end of the splitter: walks one job at a time and issues one flash
// operation per cycle, unless the receiver stalls, into the output register. Depends on fwes_pkg.
module fwes_back import fwes_pkg::*; #(
  parameter int unsigned PAGE_BYTES      = 256,
  parameter int unsigned SECTOR_BYTES    = 65536,
  parameter int unsigned SUBSECTOR_BYTES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Queue pop side
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               pop_o,
  // Operation channel
  output logic               op_valid_o,
  input  logic               op_ready_i,
  output logic [1:0]         op_code_o,
  output logic [ADDR_W-1:0]  op_addr_o,
  output logic [BYTES_W-1:0] op_bytes_o,
  output logic [1:0]         op_status_o,
  output logic               op_last_o
);

  localparam int unsigned WideW = ADDR_W + 1;
  localparam logic [ADDR_W-1:0] PageMask = ADDR_W'(PAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0] SecMask  = ADDR_W'(SECTOR_BYTES - 1);
  localparam logic [WideW-1:0]  PageW    = WideW'(PAGE_BYTES);
  localparam logic [WideW-1:0]  SectorW  = WideW'(SECTOR_BYTES);
  localparam logic [WideW-1:0]  SubW     = WideW'(SUBSECTOR_BYTES);
  localparam logic [RESULT_CNT_W-1:0] LastIdx = RESULT_CNT_W'(RESULT_LIMIT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                    state_q, state_d;
  job_kind_e               kind_q;
  logic [1:0]              status_q;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [COUNT_W-1:0]      rem_q, rem_d;
  logic [RESULT_CNT_W-1:0] nres_q, nres_d;

  logic                    out_valid_q;
  logic [1:0]              out_code_q;
  logic [ADDR_W-1:0]       out_addr_q;
  logic [BYTES_W-1:0]      out_bytes_q;
  logic [1:0]              out_status_q;
  logic                    out_last_q;

  logic              load, emit, fin;
  logic [WideW-1:0]  rem_w, page_room, step, rem_after;
  logic [1:0]        code;
  logic              sector_ok;

  assign load  = (state_q == ST_IDLE) && job_valid_i;
  assign emit  = (state_q == ST_RUN) && (!out_valid_q || op_ready_i);
  assign pop_o = load;

  // Size of the next operation and whether it ends the run.
  always_comb begin
    rem_w     = WideW'(rem_q);
    page_room = PageW - WideW'(addr_q & PageMask);
    sector_ok = ((addr_q & SecMask) == '0) && (rem_w >= SectorW);
    step      = '0;
    code      = OP_NONE;
    fin       = 1'b1;
    case (kind_q)
      JOB_WRITE: begin
        code = OP_PROGRAM;
        step = (page_room > rem_w) ? rem_w : page_room;
        fin  = (rem_w == step);
      end
      JOB_ERASE: begin
        code = sector_ok ? OP_SECTOR : OP_SUBSECTOR;
        step = sector_ok ? SectorW : SubW;
        fin  = ((rem_w - step) < SubW);
      end
      default: begin
        code = OP_NONE;
        step = '0;
        fin  = 1'b1;
      end
    endcase
    rem_after = rem_w - step;
    if (nres_q == LastIdx) begin
      fin = 1'b1;
    end
  end

  // Job walker.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    rem_d   = rem_q;
    nres_d  = nres_q;
    if (load) begin
      state_d = ST_RUN;
      addr_d  = job_i.addr;
      rem_d   = job_i.count;
      nres_d  = '0;
    end else if (emit) begin
      addr_d = addr_q + step[ADDR_W-1:0];
      rem_d  = rem_after[COUNT_W-1:0];
      nres_d = nres_q + RESULT_CNT_W'(1);
      if (fin) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= JOB_NONE;
      status_q    <= ST_OK;
      addr_q      <= '0;
      rem_q       <= '0;
      nres_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      rem_q   <= rem_d;
      nres_q  <= nres_d;
      if (load) begin
        kind_q   <= job_i.kind;
        status_q <= job_i.status;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (op_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register; it holds while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_code_q   <= code;
      out_addr_q   <= (code == OP_NONE) ? '0 : addr_q;
      out_bytes_q  <= (code == OP_PROGRAM) ? step[BYTES_W-1:0] : '0;
      out_status_q <= (code == OP_NONE) ? status_q : ST_OK;
      out_last_q   <= fin;
    end
  end

  assign op_valid_o  = out_valid_q;
  assign op_code_o   = out_code_q;
  assign op_addr_o   = out_addr_q;
  assign op_bytes_o  = out_bytes_q;
  assign op_status_o = out_status_q;
  assign op_last_o   = out_last_q;

endmodule

/* rtl/flash_write_erase_splitter_core.sv */
// Top level of the flash write/erase splitter.
// Instantiates fwes_front, fwes_queue and fwes_back; depends on fwes_pkg.
// Usage:
//   The request channel (s_axis) carries a write or erase request: tuser is
//   the command (0 write, 1 erase), tdata the start address and byte count.
//   The result channel (m_axis) gives one flash operation per transfer: tuser
//   is the operation code, tdata the address, page-program byte count and
//   status, tlast marks the final operation of a request.
//   The configuration channel writes region_start (index 0) and region_end
//   (index 1); it is always ready, and the user must write it only while the
//   block is idle, as the block itself does not enforce this. A request is
//   pushed into the job queue and loaded by the walker; its operations are
//   registered in the output register, one per cycle while the receiver does
//   not stall, up to 33 per request. Requests are taken while the two-entry
//   job queue has room, so the next request is classified while the walker
//   runs. When the receiver stalls, the output register holds its operation
//   and the walker waits; the queue then fills and s_axis_tready drops.
//   Reset clears the queue, the walker and the output valid, and sets the
//   region to the full 16 MiB address space.
//   Page, sector and subsector sizes must be powers of two.
module flash_write_erase_splitter_core import fwes_pkg::*; #(
  parameter int unsigned PAGE_BYTES      = 256,
  parameter int unsigned SECTOR_BYTES    = 65536,
  parameter int unsigned SUBSECTOR_BYTES = 4096,
  parameter int unsigned MAX_WRITE_BYTES = 8192,
  parameter int unsigned MAX_ERASE_BYTES = 131072
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [REGEND_W-1:0] cfg_data_i,
  // Request channel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // start_address[23:0], byte_count[41:24], zero pad
  input  logic                s_axis_tuser,  // command
  // Operation channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,  // op_address[23:0], op_bytes[32:24], status[34:33]
  output logic [1:0]          m_axis_tuser,  // operation
  output logic                m_axis_tlast
);

  logic               push, full, pop, job_valid;
  job_t               job_in, job_out;
  logic [1:0]         op_status;
  logic [ADDR_W-1:0]  op_addr;
  logic [BYTES_W-1:0] op_bytes;

  assign cfg_ready_o = 1'b1;

  fwes_front #(
    .SUBSECTOR_BYTES (SUBSECTOR_BYTES),
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES),
    .MAX_ERASE_BYTES (MAX_ERASE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (s_axis_tuser),
    .req_addr_i  (s_axis_tdata[ADDR_W-1:0]),
    .req_count_i (s_axis_tdata[ADDR_W+COUNT_W-1:ADDR_W]),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job_in)
  );

  fwes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  fwes_back #(
    .PAGE_BYTES      (PAGE_BYTES),
    .SECTOR_BYTES    (SECTOR_BYTES),
    .SUBSECTOR_BYTES (SUBSECTOR_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .op_valid_o  (m_axis_tvalid),
    .op_ready_i  (m_axis_tready),
    .op_code_o   (m_axis_tuser),
    .op_addr_o   (op_addr),
    .op_bytes_o  (op_bytes),
    .op_status_o (op_status),
    .op_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, op_status, op_bytes, op_addr};

endmodule

/* rtl/fwes_checker.sv */
// Port-level checker for the flash write/erase splitter, bound to the top
// level. Depends on fwes_pkg for the operation and status codes.
module fwes_checker import fwes_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled operation stays and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled operation changed");

  // A 'none' result always ends its run and carries a zero address and byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == OP_NONE |-> m_axis_tlast
      && m_axis_tdata[23:0] == '0 && m_axis_tdata[32:24] == '0)
    else $error("none result malformed");

  // Real flash operations carry an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != OP_NONE |-> m_axis_tdata[34:33] == ST_OK)
    else $error("operation with error status");

  // Erases carry no byte count; page programs carry a nonzero one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == OP_PROGRAM) == (m_axis_tdata[32:24] != '0)))
    else $error("byte count does not match operation");

endmodule

bind flash_write_erase_splitter_core fwes_checker u_fwes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
